@@ src/arpc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arpc_pkg: shared definitions for the rotator preset controller
// Item kinds, register indexes, flag positions, controller states and the
// command and status groups passed between controller and datapath.
// ---------------------------------------------------------------------------
package arpc_pkg;

	typedef enum logic [2:0] {
		KIND_SAMPLE = 3'd0,
		KIND_TARGET = 3'd1,
		KIND_CW     = 3'd2,
		KIND_CCW    = 3'd3,
		KIND_STOP   = 3'd4,
		KIND_TICK   = 3'd5,
		KIND_QUERY  = 3'd6,
		KIND_SPARE  = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		REG_AD_LOW     = 3'd0,
		REG_AD_HIGH    = 3'd1,
		REG_ANG_START  = 3'd2,
		REG_ANG_STOP   = 3'd3,
		REG_OVL_NORTH  = 3'd4,
		REG_BRAKE_WAIT = 3'd5,
		REG_SETTLE     = 3'd6,
		REG_BRAKE_FIT  = 3'd7
	} reg_idx_t;

	// Mode flag positions, as in the low status bits.
	localparam int FL_CW     = 0;
	localparam int FL_CCW    = 1;
	localparam int FL_IDLE   = 2;
	localparam int FL_PRESET = 3;
	localparam int FL_NORTH  = 4;

	// Relay positions.
	localparam int RL_CW    = 0;
	localparam int RL_CCW   = 1;
	localparam int RL_BRAKE = 2;

	localparam int DIV_STEPS = 22;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic signed [15:0] HALF_TURN = 16'sd180;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIX,
		ST_APPLY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic load;
		logic step;
		logic fix;
		logic apply;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic out_free;
	} stat_t;

endpackage

@@ src/antenna_rotator_preset_controller_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// antenna_rotator_preset_controller_core: rotator preset controller top level
// Hardwired rotator control: pot samples, targets, manual moves, stops and
// tenth-second ticks in; relay drives, headings and status out.
// ---------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result item for
// each. A pot sample passes through dispatch, a multiply, a load, the
// bit-serial divider that scales the reading to degrees, a fix-up and a
// commit; every other kind commits its state change at dispatch and is then
// handed over. A new item is accepted once the previous one has been handed
// to the result register, so a waiting result does not block the next item.
// Configuration writes are always accepted and should only be made while the
// block is idle.
module antenna_rotator_preset_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // ad_sample[9:0], target_angle[25:10], zero fill
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	// motor_cw[0], motor_ccw[1], brake_released[2], heading_now[18:3],
	// heading_goal[34:19], status_bits[40:35], status_push[41], zero fill
	output logic [47:0] m_tdata,
	// Register writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import arpc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Registers are single flip-flop writes, so the port never stalls.
	assign cfg_ready = 1'b1;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	arpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_ad     (s_tdata[9:0]),
		.in_target (s_tdata[25:10]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ src/arpc_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arpc_ctrl: sequencer of the rotator preset controller
// Steps each pot sample through multiply, divide, heading fix-up, state
// update and result hand-over; other items go straight to state update.
// ---------------------------------------------------------------------------
module arpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  arpc_pkg::stat_t stat,
	output logic          in_ready,
	output arpc_pkg::cmd_t  cmd
);
	import arpc_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (stat.is_sample) begin
					state_d = ST_MUL;
				end else begin
					cmd.apply = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// Samples commit their state change here, with the new heading.
				if (stat.out_free) begin
					cmd.apply = stat.is_sample;
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> $past(state_q) == ST_DIV && $past(cnt_q) == CNT_W'(DIV_STEPS - 1))
		else $error("divide left early");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result emitted over a waiting one");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_APPLY)
		else $error("capture not followed by dispatch");

endmodule

@@ src/arpc_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arpc_dp: datapath of the rotator preset controller
// Configuration, heading scaling with a serial divider, mode flags, timers,
// relays and the result register.
// ---------------------------------------------------------------------------
module arpc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  arpc_pkg::cmd_t  cmd,
	output arpc_pkg::stat_t stat,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic [2:0]    in_kind,
	input  logic [9:0]    in_ad,
	input  logic [15:0]   in_target,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [47:0]   out_data
);
	import arpc_pkg::*;

	// Configuration.
	logic [9:0] ad_lo_q, ad_hi_q;
	logic signed [10:0] ang_start_q, ang_stop_q;
	logic ovl_q, fit_q;
	logic [15:0] bwait_q;
	logic [12:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_lo_q <= 10'd100;
			ad_hi_q <= 10'd900;
			ang_start_q <= 11'sd0;
			ang_stop_q <= 11'sd360;
			ovl_q <= 1'b0;
			bwait_q <= 16'd10;
			settle_q <= 13'd10;
			fit_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_AD_LOW:     ad_lo_q <= cfg_data[9:0];
				REG_AD_HIGH:    ad_hi_q <= cfg_data[9:0];
				REG_ANG_START:  ang_start_q <= cfg_data[10:0];
				REG_ANG_STOP:   ang_stop_q <= cfg_data[10:0];
				REG_OVL_NORTH:  ovl_q <= cfg_data[0];
				REG_BRAKE_WAIT: bwait_q <= cfg_data;
				REG_SETTLE:     settle_q <= cfg_data[12:0];
				REG_BRAKE_FIT:  fit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Captured item.
	kind_t kind_q;
	logic [9:0] ad_q;
	logic signed [15:0] tgt_in_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(in_kind);
			ad_q <= in_ad;
			tgt_in_q <= in_target;
		end
	end

	// Scaling: product, restoring divide on magnitudes, sign and overlap fix.
	logic signed [10:0] sa;
	logic signed [11:0] sg;
	logic [9:0] den;
	logic signed [22:0] prod_s1;
	logic [21:0] num_q;
	logic [9:0] rem_q;
	logic qneg_q;
	logic [10:0] trial;
	logic signed [22:0] q;
	logic signed [24:0] t;
	logic signed [23:0] h;
	logic signed [15:0] heading_q, heading_d;
	logic sa_zero;

	assign sa = signed'({1'b0, ad_hi_q}) - signed'({1'b0, ad_lo_q});
	assign sg = 12'(ang_stop_q) - 12'(ang_start_q);
	assign den = sa[10] ? 10'(-sa) : sa[9:0];
	assign sa_zero = (sa == 11'sd0);
	assign trial = {rem_q, num_q[21]};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= 23'(signed'({1'b0, ad_q}) * sg);
		end
		if (cmd.load) begin
			num_q <= prod_s1[22] ? 22'(-prod_s1) : prod_s1[21:0];
			rem_q <= '0;
			qneg_q <= prod_s1[22] ^ sa[10];
		end else if (cmd.step) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= 10'(trial - {1'b0, den});
				num_q <= {num_q[20:0], 1'b1};
			end else begin
				rem_q <= trial[9:0];
				num_q <= {num_q[20:0], 1'b0};
			end
		end
	end

	always_comb begin
		q = sa_zero ? 23'sd0 : (qneg_q ? -signed'({1'b0, num_q}) : signed'({1'b0, num_q}));
		if (signed'({1'b0, ad_q, 1'b0}) > 12'(sa)) begin
			t = (25'(q) <<< 1) - 25'(sg);
		end else begin
			t = (25'(q) <<< 1) + 25'(sg);
		end
		h = 24'((t + 25'(t[24])) >>> 1);
		if (!ovl_q) begin
			h = 24'(q);
		end
		if (h > 24'sd32767) begin
			heading_d = 16'sh7FFF;
		end else if (h < -24'sd32768) begin
			heading_d = 16'sh8000;
		end else begin
			heading_d = h[15:0];
		end
	end

	// Controller state.
	logic [4:0] flags_q, flags_d;
	logic [2:0] relay_q, relay_d;
	logic signed [15:0] goal_q, goal_d, last_q, last_d;
	logic [15:0] st_t_q, st_t_d, br_t_q, br_t_d;
	logic [16:0] se_t_q, se_t_d;
	logic st_on_q, st_on_d, br_on_q, br_on_d, se_on_q, se_on_d;
	logic dir_q, dir_d;
	logic push_q, push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
		end else if (cmd.fix) begin
			heading_q <= heading_d;
		end
	end

	always_comb begin
		logic halt, stop_hit, bdir, bnorth, btouch;
		logic [16:0] se_load;
		logic [15:0] st_load;
		flags_d = flags_q; relay_d = relay_q; goal_d = goal_q; last_d = last_q;
		st_t_d = st_t_q; br_t_d = br_t_q; se_t_d = se_t_q;
		st_on_d = st_on_q; br_on_d = br_on_q; se_on_d = se_on_q;
		dir_d = dir_q; push_d = 1'b0;
		halt = 1'b0; stop_hit = 1'b0; bdir = 1'b0; bnorth = 1'b0; btouch = 1'b0;
		se_load = {settle_q, 3'b000} + {3'b000, settle_q, 1'b0};
		st_load = fit_q ? bwait_q : 16'd0;
		case (kind_q)
			KIND_SAMPLE: begin
				halt = (ad_q == 10'd0 && flags_q[FL_PRESET])
					|| (flags_q[FL_CW] && ad_q >= ad_hi_q)
					|| (flags_q[FL_CCW] && ad_q <= ad_lo_q);
				if (!halt && flags_q[FL_PRESET]) begin
					if (flags_q[FL_IDLE]) begin
						if (ovl_q) begin
							btouch = 1'b1;
							if (heading_q >= HALF_TURN) begin
								if (goal_q >= HALF_TURN) begin
									bdir = !(goal_q > heading_q);
								end else begin
									bdir = 1'b0; bnorth = 1'b1;
								end
							end else begin
								if (goal_q >= HALF_TURN) begin
									bdir = 1'b1; bnorth = 1'b1;
								end else begin
									bdir = !(goal_q > heading_q);
								end
							end
						end else begin
							bdir = !(heading_q < goal_q);
						end
						flags_d[FL_CW] = !bdir;
						flags_d[FL_CCW] = bdir;
						flags_d[FL_IDLE] = 1'b0;
						if (btouch) begin
							flags_d[FL_NORTH] = bnorth;
						end
						relay_d[RL_CW] = !bdir;
						relay_d[RL_CCW] = bdir;
					end else if (ovl_q && flags_q[FL_NORTH]) begin
						if (flags_q[FL_CW]) begin
							stop_hit = heading_q < HALF_TURN && heading_q >= goal_q;
						end else if (flags_q[FL_CCW]) begin
							stop_hit = heading_q >= HALF_TURN && heading_q <= goal_q;
						end
					end else begin
						if (flags_q[FL_CW]) begin
							stop_hit = heading_q >= goal_q;
						end else if (flags_q[FL_CCW]) begin
							stop_hit = heading_q <= goal_q;
						end
					end
				end
				push_d = halt | stop_hit;
				halt = halt | stop_hit;
			end
			KIND_TARGET: begin
				goal_d = tgt_in_q;
				flags_d[FL_PRESET] = 1'b1;
			end
			KIND_CW, KIND_CCW: begin
				if (flags_q[FL_IDLE]) begin
					bdir = (kind_q == KIND_CCW);
					dir_d = bdir;
					if (fit_q) begin
						relay_d[RL_BRAKE] = 1'b1;
					end
					st_t_d = st_load;
					if (st_load == 16'd0) begin
						st_on_d = 1'b0;
						relay_d[RL_CW] = !bdir;
						relay_d[RL_CCW] = bdir;
					end else begin
						st_on_d = 1'b1;
					end
					flags_d[FL_IDLE] = 1'b0;
					flags_d[FL_PRESET] = 1'b0;
					flags_d[FL_CW] = flags_q[FL_CW] | !bdir;
					flags_d[FL_CCW] = flags_q[FL_CCW] | bdir;
				end
			end
			KIND_STOP: begin
				halt = flags_q[FL_CW] | flags_q[FL_CCW];
			end
			KIND_TICK: begin
				if (st_on_q) begin
					if (st_t_q > 16'd1) begin
						st_t_d = st_t_q - 16'd1;
					end else begin
						st_on_d = 1'b0;
						relay_d[RL_CW] = !dir_q;
						relay_d[RL_CCW] = dir_q;
					end
				end
				if (br_on_q) begin
					if (br_t_q > 16'd1) begin
						br_t_d = br_t_q - 16'd1;
					end else begin
						br_on_d = 1'b0;
						relay_d[RL_BRAKE] = 1'b0;
					end
				end
				if (se_on_q) begin
					if (se_t_q > 17'd1) begin
						se_t_d = se_t_q - 17'd1;
					end else begin
						se_on_d = 1'b0;
						if (!flags_q[FL_CW] && !flags_q[FL_CCW]) begin
							flags_d[FL_IDLE] = 1'b1;
						end
					end
				end
				push_d = (heading_q != last_q);
			end
			default: ;
		endcase
		if (halt) begin
			relay_d[RL_CW] = 1'b0;
			relay_d[RL_CCW] = 1'b0;
			flags_d[FL_CW] = 1'b0;
			flags_d[FL_CCW] = 1'b0;
			flags_d[FL_PRESET] = 1'b0;
			br_t_d = bwait_q;
			br_on_d = 1'b1;
			if (bwait_q == 16'd0) begin
				br_on_d = 1'b0;
				relay_d[RL_BRAKE] = 1'b0;
			end
			se_t_d = se_load;
			se_on_d = 1'b1;
			if (se_load == 17'd0) begin
				se_on_d = 1'b0;
				flags_d[FL_IDLE] = 1'b1;
			end
		end
		if (push_d) begin
			last_d = heading_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 5'(1 << FL_IDLE);
			relay_q <= '0;
			goal_q <= '0;
			last_q <= '0;
			st_t_q <= '0; br_t_q <= '0; se_t_q <= '0;
			st_on_q <= 1'b0; br_on_q <= 1'b0; se_on_q <= 1'b0;
			dir_q <= 1'b0;
			push_q <= 1'b0;
		end else if (cmd.apply) begin
			flags_q <= flags_d;
			relay_q <= relay_d;
			goal_q <= goal_d;
			last_q <= last_d;
			st_t_q <= st_t_d; br_t_q <= br_t_d; se_t_q <= se_t_d;
			st_on_q <= st_on_d; br_on_q <= br_on_d; se_on_q <= se_on_d;
			dir_q <= dir_d;
			push_q <= push_d;
		end
	end

	// Result register. A sample's state change commits in the emit cycle, so
	// the result is built from the values about to be stored.
	logic out_valid_q;
	logic [47:0] out_data_q;
	logic [2:0] r_relay;
	logic [4:0] r_flags;
	logic signed [15:0] r_goal;
	logic r_push;

	assign r_relay = (cmd.apply) ? relay_d : relay_q;
	assign r_flags = (cmd.apply) ? flags_d : flags_q;
	assign r_goal  = (cmd.apply) ? goal_d : goal_q;
	assign r_push  = (cmd.apply) ? push_d : push_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {6'd0, r_push, !ovl_q, r_flags, r_goal, heading_q,
				r_relay[RL_BRAKE], r_relay[RL_CCW], r_relay[RL_CW]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign stat.is_sample = (kind_q == KIND_SAMPLE);
	assign stat.out_free = !out_valid_q || out_ready;

	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(relay_q[RL_CW] && relay_q[RL_CCW]))
		else $error("both motor relays driven");
	a_idle_still: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[FL_IDLE] |-> !flags_q[FL_CW] && !flags_q[FL_CCW])
		else $error("idle while moving");
	a_push_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && push_d) |=> last_q == $past(heading_q))
		else $error("pushed heading not recorded");

endmodule
